// File: hdl/sorted_value_frequency_table_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted value frequency table
// Shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef SORTED_VALUE_FREQUENCY_TABLE_MACROS_SVH
`define SORTED_VALUE_FREQUENCY_TABLE_MACROS_SVH

// A property that must hold in every cycle outside reset.
`define SVFT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition in one cycle that forces a consequence in the next cycle.
`define SVFT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/svft_pkg.sv
// ----------------------------------------------------------------------------
// svft_pkg
// Types, constants and helpers shared by the frequency table and its cells.
// ----------------------------------------------------------------------------
package svft_pkg;

  localparam int Capacity  = 32;
  localparam int CountBits = 16;
  localparam int OccBits   = $clog2(Capacity + 1);

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DUMP   = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_NEW  = 2'd0,
    ST_DUP  = 2'd1,
    ST_FULL = 2'd2,
    ST_DUMP = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_SORT   = 2'd2,
    CMD_ROTATE = 2'd3
  } cmd_e;

  typedef struct packed {
    op_e                op;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] entry_value;
    logic [15:0]        entry_count;
    status_e            status;
    logic               last;
  } rsp_t;

  typedef struct packed {
    logic signed [31:0]   value;
    logic [CountBits-1:0] count;
  } entry_t;

  // Per-cell control issued by the sequencer.
  typedef struct packed {
    cmd_e cmd;
    logic valid;    // cell holds an occupied entry
    logic tail;     // cell holds the last occupied entry
    logic lead;     // cell is the left member of a pair in this sort phase
    logic pair_ok;  // right neighbor is occupied too
    logic append;   // cell takes the new value on this insert
  } cell_ctl_t;

  // Low 16 bits of a count, zero-extended when counts are narrower.
  function automatic logic [15:0] count_out(logic [CountBits-1:0] c);
    logic [CountBits+15:0] w;
    w = {16'b0, c};
    return w[15:0];
  endfunction

endpackage

// File: hdl/svft_cell.sv
// ----------------------------------------------------------------------------
// svft_cell
// One table entry: matches and counts, compare-swaps with its right neighbor
// during the sort, and shifts toward the head while the table is streamed.
// ----------------------------------------------------------------------------
module svft_cell (
  input  logic                         clk_i,
  input  svft_pkg::cell_ctl_t          ctl_i,
  input  logic signed [31:0]           key_i,
  input  svft_pkg::entry_t             left_i,
  input  svft_pkg::entry_t             right_i,
  input  svft_pkg::entry_t             head_i,
  input  logic                         swap_left_i,
  output svft_pkg::entry_t             ent_o,
  output logic                         swap_o,
  output logic                         match_o,
  output logic [svft_pkg::CountBits-1:0] hit_cnt_o
);

  svft_pkg::entry_t               ent_q, ent_d;
  logic [svft_pkg::CountBits-1:0] bumped;

  assign match_o = ctl_i.valid && (ent_q.value == key_i);
  assign bumped  = (&ent_q.count) ? ent_q.count
                                  : ent_q.count + svft_pkg::CountBits'(1);
  assign hit_cnt_o = match_o ? bumped : '0;
  assign swap_o  = ctl_i.lead && ctl_i.pair_ok &&
                   ($signed(ent_q.value) > $signed(right_i.value));

  always_comb begin
    ent_d = ent_q;
    case (ctl_i.cmd)
      svft_pkg::CMD_INSERT: begin
        if (match_o) begin
          ent_d.count = bumped;
        end else if (ctl_i.append) begin
          ent_d.value = key_i;
          ent_d.count = svft_pkg::CountBits'(1);
        end
      end
      svft_pkg::CMD_SORT: begin
        if (swap_o) begin
          ent_d = right_i;
        end else if (swap_left_i) begin
          ent_d = left_i;
        end
      end
      svft_pkg::CMD_ROTATE: begin
        // The head entry wraps into the tail so the table is whole again
        // once every occupied entry has passed the head.
        if (ctl_i.valid) begin
          ent_d = ctl_i.tail ? head_i : right_i;
        end
      end
      default: ent_d = ent_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o = ent_q;

endmodule

// File: hdl/sorted_value_frequency_table.sv
// ----------------------------------------------------------------------------
// sorted_value_frequency_table
// Counts occurrences of distinct signed values in a chain of entry cells and
// dumps the entries in ascending order on request.
// ----------------------------------------------------------------------------
//  channel   handshake                  payload
//  request   start_i, busy_o            req_i   (op, value)
//  result    result_valid_o (strobe)    rsp_o   (entry_value, entry_count,
//                                                status, last)
//
//  On an insert, all cells compare against the value in the insert state
//  and the result strobe follows in the cycle after; busy_o drops with it.
//  A dump of N entries runs N odd-even transposition phases through the
//  cell chain, then rotates the entries past the head cell, one result a
//  cycle. A dump of an empty table gives no result and busy_o stays low.
//  Reset empties the table at once; results cannot be stalled.
// ----------------------------------------------------------------------------
`include "sorted_value_frequency_table_macros.svh"

module sorted_value_frequency_table (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  svft_pkg::req_t req_i,
  output logic           result_valid_o,
  output svft_pkg::rsp_t rsp_o
);

  localparam int Cap     = svft_pkg::Capacity;
  localparam int OccBits = svft_pkg::OccBits;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_INS  = 4'b0010,
    S_SORT = 4'b0100,
    S_DUMP = 4'b1000
  } state_e;

  state_e               state_q, state_d;
  logic [OccBits-1:0]   occ_q, occ_d;
  logic [OccBits-1:0]   cnt_q, cnt_d;
  logic signed [31:0]   key_q;
  logic                 valid_q, valid_d;
  svft_pkg::rsp_t       rsp_q, rsp_d;

  svft_pkg::cmd_e                 cmd;
  svft_pkg::cell_ctl_t            ctl   [Cap];
  svft_pkg::entry_t               ent   [Cap];
  logic [svft_pkg::CountBits-1:0] hit   [Cap];
  logic [Cap-1:0]                 match;
  logic [Cap-1:0]                 swap;
  logic                           any_match;
  logic                           full;
  logic [svft_pkg::CountBits-1:0] hit_cnt;
  logic [OccBits-1:0]             occ_last;

  assign any_match = |match;
  assign full      = (occ_q == OccBits'(Cap));
  assign occ_last  = occ_q - OccBits'(1);

  always_comb begin
    case (state_q)
      S_INS:   cmd = svft_pkg::CMD_INSERT;
      S_SORT:  cmd = svft_pkg::CMD_SORT;
      S_DUMP:  cmd = svft_pkg::CMD_ROTATE;
      default: cmd = svft_pkg::CMD_HOLD;
    endcase
  end

  for (genvar i = 0; i < Cap; i++) begin : g_cell
    assign ctl[i].cmd     = cmd;
    assign ctl[i].valid   = OccBits'(i) < occ_q;
    assign ctl[i].tail    = occ_q == OccBits'(i + 1);
    assign ctl[i].lead    = ((i % 2) == 1) == cnt_q[0];
    assign ctl[i].pair_ok = OccBits'(i + 1) < occ_q;
    assign ctl[i].append  = (occ_q == OccBits'(i)) && !any_match;

    svft_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl[i]),
      .key_i       (key_q),
      .left_i      ((i == 0) ? ent[i] : ent[(i == 0) ? 0 : i - 1]),
      .right_i     ((i == Cap - 1) ? ent[i] : ent[(i == Cap - 1) ? i : i + 1]),
      .head_i      (ent[0]),
      .swap_left_i ((i == 0) ? 1'b0 : swap[(i == 0) ? 0 : i - 1]),
      .ent_o       (ent[i]),
      .swap_o      (swap[i]),
      .match_o     (match[i]),
      .hit_cnt_o   (hit[i])
    );
  end

  always_comb begin
    hit_cnt = '0;
    for (int i = 0; i < Cap; i++) begin
      hit_cnt = hit_cnt | hit[i];
    end
  end

  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    occ_d   = occ_q;
    cnt_d   = cnt_q;
    valid_d = 1'b0;
    rsp_d   = rsp_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cnt_d = '0;
          if (req_i.op == svft_pkg::OP_INSERT) begin
            state_d = S_INS;
          end else if (occ_q != '0) begin
            state_d = S_SORT;
          end
        end
      end
      S_INS: begin
        rsp_d.entry_value = key_q;
        rsp_d.last        = 1'b1;
        valid_d           = 1'b1;
        if (any_match) begin
          rsp_d.entry_count = svft_pkg::count_out(hit_cnt);
          rsp_d.status      = svft_pkg::ST_DUP;
        end else if (!full) begin
          rsp_d.entry_count = 16'd1;
          rsp_d.status      = svft_pkg::ST_NEW;
          occ_d             = occ_q + OccBits'(1);
        end else begin
          rsp_d.entry_count = 16'd0;
          rsp_d.status      = svft_pkg::ST_FULL;
        end
        state_d = S_IDLE;
      end
      S_SORT: begin
        // N phases of odd-even transposition order N entries.
        if (cnt_q == occ_last) begin
          cnt_d   = '0;
          state_d = S_DUMP;
        end else begin
          cnt_d = cnt_q + OccBits'(1);
        end
      end
      S_DUMP: begin
        rsp_d.entry_value = ent[0].value;
        rsp_d.entry_count = svft_pkg::count_out(ent[0].count);
        rsp_d.status      = svft_pkg::ST_DUMP;
        rsp_d.last        = (cnt_q == occ_last);
        valid_d           = 1'b1;
        if (cnt_q == occ_last) begin
          state_d = S_IDLE;
        end else begin
          cnt_d = cnt_q + OccBits'(1);
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      occ_q   <= '0;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
    if (start_i && state_q == S_IDLE) begin
      key_q <= req_i.value;
    end
  end

  assign result_valid_o = valid_q;
  assign rsp_o          = rsp_q;

  // Stored values stay distinct, so a request can hit at most one cell.
  `SVFT_ASSERT(a_single_match, $onehot0(match), "more than one cell matched the request")

  `SVFT_ASSERT_NEXT(a_append_grows, state_q == S_INS && !any_match && !full,
                    occ_q == $past(occ_q) + OccBits'(1), "append did not grow the table")

  `SVFT_ASSERT(a_quiet_sort, !(state_q == S_SORT && result_valid_o),
               "result strobe while sorting")

  `SVFT_ASSERT(a_insert_last, !(result_valid_o && rsp_o.status != svft_pkg::ST_DUMP &&
                                !rsp_o.last), "insert result without last")

endmodule
